/* rtl/rwis_pkg.sv */
// Package for the row window interval set: payload types, codes, states.
package rwis_pkg;

	localparam int unsigned ROWS_DEFAULT = 64;
	localparam int unsigned SEGMENTS_DEFAULT = 16;

	typedef enum logic [2:0] {
		OP_WINDOW = 3'd0,
		OP_ALL    = 3'd1,
		OP_NIL    = 3'd2,
		OP_QUERY  = 3'd3,
		OP_ROUND  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_SOME = 2'd1,
		MODE_ALL  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [5:0]         row;
		logic signed [15:0] offset;
		logic signed [15:0] length;
		logic [14:0]        row_length;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  window_state;
		logic [14:0] covered;
		logic [4:0]  segment_count;
		logic        overflow;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HEAD,
		ST_SCAN_RD,
		ST_SCAN,
		ST_MERGE,
		ST_TAIL,
		ST_SHIFT_RD,
		ST_SHIFT,
		ST_INSERT,
		ST_DONE
	} state_t;

endpackage

/* rtl/row_window_interval_set.sv */
// Top level of the row window interval set: row table, segment memory, sequencer.
//
// One transfer in gives one transfer out. Queries, stage all, stage nil, new
// rounds and invalid windows pass from the accept state through a head state
// to the result state. A window that must be merged scans the row's stored
// segments through a registered memory read, a read state and a compare state
// per segment, and an in-order insertion then moves every later segment up by
// one, again with a read state and a write state per segment. Scan and shift
// together touch at most SEGMENTS segments. A receiver that holds off stalls
// the block in its result state. The per-row table (round tag, mode, covered
// length, count) is a memory that is read into working registers when a
// transfer is accepted and written back when the result is produced. Neither
// memory is cleared: a row whose per-row valid bit is low is treated as
// stale, and only segment entries below the row's count are ever read. A new
// round that wraps the 16-bit round counter invalidates every row at once
// through those valid bits. The block works on one item at a time. A new item
// may be accepted while the previous result still waits in the result
// register; it then stalls in its result state until that register is free.
module row_window_interval_set #(
	parameter int unsigned ROWS = rwis_pkg::ROWS_DEFAULT,
	parameter int unsigned SEGMENTS = rwis_pkg::SEGMENTS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rwis_pkg::in_item_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rwis_pkg::out_item_t out_data
);
	import rwis_pkg::*;

	localparam int unsigned RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned CW = $clog2(SEGMENTS + 1);
	localparam int unsigned AW = $clog2(ROWS * SEGMENTS);
	localparam int unsigned MAXW = 6;

	// Per-row table. The valid bits are flip-flops so that a wrap can drop them all.
	logic [ROWS-1:0]   tag_valid_q;
	logic [15:0]       row_round_mem [ROWS];
	mode_t             row_mode_mem [ROWS];
	logic [14:0]       row_cov_mem [ROWS];
	logic [CW-1:0]     row_cnt_mem [ROWS];
	logic [15:0]       round_q;

	// Registered read of the addressed row and its working copy.
	logic [15:0]       rd_round_q;
	mode_t             rd_mode_q;
	logic [14:0]       rd_cov_q;
	logic [CW-1:0]     rd_cnt_q;
	logic [15:0]       round_tag_q;
	mode_t             mode_q;
	logic [14:0]       cov_q;
	logic [CW-1:0]     cnt_q;

	logic [29:0]       seg_mem [ROWS*SEGMENTS];
	logic [29:0]       rd_q;

	state_t            state_q, state_d;
	in_item_t          item_q;
	logic [RW-1:0]     r_q;
	logic [CW-1:0]     n_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     j_q;
	logic signed [17:0] zl_q;
	logic              ovf_q;
	logic              in_range_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              fresh, fresh_rd;
	logic              stage_op, bad_win, full_win, out_free;
	logic              row_rd_en, row_wr_en;
	logic [RW-1:0]     row_sel;
	logic signed [17:0] off_e, len_e, end_e, so_e, sl_e, send_e, rl_e;
	logic signed [17:0] no_e, nl_e, zl_new;
	logic              rd_en;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic              wr_en;
	logic [29:0]       wr_data;

	assign fresh    = tag_valid_q[r_q] && (round_tag_q == round_q);
	assign fresh_rd = tag_valid_q[r_q] && (rd_round_q == round_q);
	assign off_e = 18'(item_q.offset);
	assign len_e = 18'(item_q.length);
	assign end_e = off_e + len_e;
	assign rl_e  = {3'b000, item_q.row_length};
	assign so_e  = {3'b000, rd_q[14:0]};
	assign sl_e  = {3'b000, rd_q[29:15]};
	assign send_e = so_e + sl_e;
	assign no_e  = (so_e < off_e) ? so_e : off_e;
	assign nl_e  = ((send_e > end_e) ? send_e : end_e) - no_e;
	assign zl_new = zl_q + nl_e - sl_e;

	assign stage_op = in_range_q && (item_q.opcode == OP_WINDOW || item_q.opcode == OP_ALL
			|| item_q.opcode == OP_NIL);
	assign bad_win  = (off_e < 0) || (len_e <= 0) || (end_e > rl_e);
	assign full_win = (off_e == 0) && (len_e == rl_e);
	assign out_free = !out_valid_q || out_ready;

	assign row_sel   = RW'(in_data.row);
	assign row_rd_en = (state_q == ST_IDLE) && in_valid;
	assign row_wr_en = (state_q == ST_DONE) && out_free && in_range_q;

	function automatic logic [14:0] sat15(input logic signed [17:0] v);
		logic [14:0] res;
		if (v < 0) begin
			res = '0;
		end else if (v > 18'sd32767) begin
			res = 15'h7fff;
		end else begin
			res = v[14:0];
		end
		return res;
	endfunction

	function automatic logic [AW-1:0] seg_addr(input logic [RW-1:0] r,
			input logic [CW-1:0] k);
		logic [AW+MAXW:0] a;
		a = (AW+MAXW+1)'(r) * (AW+MAXW+1)'(SEGMENTS) + (AW+MAXW+1)'(k);
		return a[AW-1:0];
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_HEAD;
				end
			end
			ST_HEAD: begin
				if (in_range_q && item_q.opcode == OP_WINDOW && !bad_win && !full_win) begin
					state_d = ST_SCAN_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN_RD: begin
				state_d = (i_q < n_q) ? ST_SCAN : ST_TAIL;
			end
			ST_SCAN: begin
				if (off_e == so_e && len_e == sl_e) begin
					state_d = ST_DONE;
				end else if (end_e < so_e) begin
					state_d = ST_TAIL;
				end else if (off_e > send_e) begin
					state_d = ST_SCAN_RD;
				end else begin
					state_d = ST_MERGE;
				end
			end
			ST_MERGE: state_d = ST_DONE;
			ST_TAIL: begin
				if (zl_q + len_e == rl_e || n_q >= CW'(SEGMENTS)) begin
					state_d = ST_DONE;
				end else if (n_q > i_q) begin
					state_d = ST_SHIFT_RD;
				end else begin
					state_d = ST_INSERT;
				end
			end
			ST_SHIFT_RD: state_d = ST_SHIFT;
			ST_SHIFT:    state_d = (j_q - 1'b1 > i_q) ? ST_SHIFT_RD : ST_INSERT;
			ST_INSERT:   state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = seg_addr(r_q, i_q);
		wr_en   = 1'b0;
		wr_addr = seg_addr(r_q, i_q);
		wr_data = {item_q.length[14:0], item_q.offset[14:0]};
		unique case (state_q)
			ST_SCAN_RD:  rd_en = 1'b1;
			ST_SHIFT_RD: begin
				rd_en   = 1'b1;
				rd_addr = seg_addr(r_q, j_q - 1'b1);
			end
			ST_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = seg_addr(r_q, j_q);
				wr_data = rd_q;
			end
			ST_MERGE: begin
				wr_en   = 1'b1;
				wr_addr = seg_addr(r_q, i_q - 1'b1);
				wr_data = {nl_e[14:0], no_e[14:0]};
			end
			ST_INSERT: wr_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			seg_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= seg_mem[rd_addr];
		end
		if (row_wr_en) begin
			row_round_mem[r_q] <= round_tag_q;
			row_mode_mem[r_q]  <= mode_q;
			row_cov_mem[r_q]   <= cov_q;
			row_cnt_mem[r_q]   <= cnt_q;
		end
		if (row_rd_en) begin
			rd_round_q <= row_round_mem[row_sel];
			rd_mode_q  <= row_mode_mem[row_sel];
			rd_cov_q   <= row_cov_mem[row_sel];
			rd_cnt_q   <= row_cnt_mem[row_sel];
		end
	end

	// Sequencer datapath and working copy of the row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tag_valid_q <= '0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q     <= in_data;
						r_q        <= RW'(in_data.row);
						in_range_q <= (32'(in_data.row) < ROWS);
						ovf_q      <= 1'b0;
						i_q        <= '0;
					end
				end
				ST_HEAD: begin
					// A stale row starts over in the current round when it is staged.
					round_tag_q <= stage_op ? round_q : rd_round_q;
					cnt_q       <= (stage_op && !fresh_rd) ? '0 : rd_cnt_q;
					n_q         <= fresh_rd ? rd_cnt_q : '0;
					zl_q        <= fresh_rd ? {3'b000, rd_cov_q} : '0;
					if (stage_op) begin
						tag_valid_q[r_q] <= 1'b1;
						if (item_q.opcode == OP_NIL
								|| (item_q.opcode == OP_WINDOW && bad_win)) begin
							mode_q <= MODE_NONE;
							cov_q  <= '0;
						end else if (item_q.opcode == OP_ALL || full_win) begin
							mode_q <= MODE_ALL;
							cov_q  <= item_q.row_length;
						end else begin
							mode_q <= MODE_SOME;
							cov_q  <= fresh_rd ? rd_cov_q : '0;
						end
					end else begin
						mode_q <= rd_mode_q;
						cov_q  <= rd_cov_q;
						if (in_range_q && item_q.opcode == OP_ROUND) begin
							round_q <= round_q + 16'd1;
							if (round_q == 16'hffff) begin
								tag_valid_q <= '0;
							end
						end
					end
				end
				ST_SCAN_RD: begin
					if (i_q < n_q) begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (end_e < so_e) begin
						i_q <= i_q - 1'b1;
					end
				end
				ST_MERGE: begin
					if (zl_new == rl_e) begin
						mode_q <= MODE_ALL;
					end
					cov_q <= sat15(zl_new);
				end
				ST_TAIL: begin
					j_q <= n_q;
					if (zl_q + len_e == rl_e) begin
						mode_q <= MODE_ALL;
						cov_q  <= item_q.row_length;
					end else if (n_q >= CW'(SEGMENTS)) begin
						ovf_q <= 1'b1;
					end
				end
				ST_SHIFT: j_q <= j_q - 1'b1;
				ST_INSERT: begin
					cnt_q <= n_q + 1'b1;
					cov_q <= sat15(zl_q + len_e);
				end
				ST_DONE: begin
					if (out_free) begin
						if (in_range_q && fresh) begin
							out_q.window_state  <= mode_q;
							out_q.covered       <= cov_q;
							out_q.segment_count <= 5'(cnt_q);
						end else begin
							out_q.window_state  <= MODE_ALL;
							out_q.covered       <= '0;
							out_q.segment_count <= '0;
						end
						out_q.overflow <= ovf_q && in_range_q;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

/* sim/rwis_checker.sv */
// Checker for the row window interval set: tracks row state, predicts each result, compares.
module rwis_checker
	import rwis_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	output int        errors,
	output int        pending
);

	localparam int NROWS = ROWS_DEFAULT;
	localparam int NSEGS = SEGMENTS_DEFAULT;

	logic [15:0] round_ctr;
	logic        tag_valid [NROWS];
	logic [15:0] tag_round [NROWS];
	mode_t       row_mode [NROWS];
	logic [14:0] row_cov [NROWS];
	logic [4:0]  row_cnt [NROWS];
	logic [14:0] seg_off [NROWS][NSEGS];
	logic [14:0] seg_len [NROWS][NSEGS];

	out_item_t expected_status_q [$];

	function automatic logic [14:0] sat15(int v);
		if (v < 0) return 15'd0;
		if (v > 32767) return 15'h7fff;
		return v[14:0];
	endfunction

	function automatic logic row_fresh(int r);
		return tag_valid[r] && tag_round[r] == round_ctr;
	endfunction

	// Merges a valid, partial window into the sorted list. Returns 1 when dropped.
	function automatic logic merge_window(int r, int off, int len, int rl);
		int n, zl, i, j, so, sl, no, e1, e2, nl;
		logic left_of;
		n = row_cnt[r];
		zl = row_cov[r];
		left_of = 1'b0;
		for (i = 0; i < n; i++) begin
			so = seg_off[r][i];
			sl = seg_len[r][i];
			if (off == so && len == sl)
				return 1'b0;
			if (off + len < so) begin
				left_of = 1'b1;
				break;
			end
			if (off > so + sl)
				continue;
			// Touching or overlapping: widen this segment only.
			no = so < off ? so : off;
			e1 = so + sl;
			e2 = off + len;
			nl = (e1 > e2 ? e1 : e2) - no;
			zl += nl - sl;
			seg_off[r][i] = no[14:0];
			seg_len[r][i] = nl[14:0];
			if (zl == rl)
				row_mode[r] = MODE_ALL;
			row_cov[r] = sat15(zl);
			return 1'b0;
		end
		if (zl + len == rl) begin
			row_mode[r] = MODE_ALL;
			row_cov[r] = sat15(rl);
			return 1'b0;
		end
		if (n >= NSEGS)
			return 1'b1;
		if (left_of) begin
			for (j = n; j > i; j--) begin
				seg_off[r][j] = seg_off[r][j-1];
				seg_len[r][j] = seg_len[r][j-1];
			end
		end
		seg_off[r][i] = off[14:0];
		seg_len[r][i] = len[14:0];
		row_cnt[r] = 5'(n + 1);
		row_cov[r] = sat15(zl + len);
		return 1'b0;
	endfunction

	function automatic logic stage_row(int r, mode_t m, int off, int len, int rl);
		if (!row_fresh(r)) begin
			// A stale row starts over in the current round.
			tag_valid[r] = 1'b1;
			tag_round[r] = round_ctr;
			row_cnt[r] = '0;
			row_cov[r] = '0;
		end
		row_mode[r] = m;
		if (m == MODE_NONE) begin
			row_cov[r] = '0;
			return 1'b0;
		end
		if (m == MODE_ALL) begin
			row_cov[r] = sat15(rl);
			return 1'b0;
		end
		return merge_window(r, off, len, rl);
	endfunction

	function automatic out_item_t apply_command(in_item_t c);
		int r, off, len, rl;
		logic dropped;
		out_item_t res;
		r = c.row;
		off = c.offset;
		len = c.length;
		rl = c.row_length;
		dropped = 1'b0;
		case (c.opcode)
			OP_WINDOW: begin
				if (off < 0 || len <= 0 || off + len > rl)
					dropped = stage_row(r, MODE_NONE, 0, 0, rl);
				else if (off == 0 && len == rl)
					dropped = stage_row(r, MODE_ALL, 0, 0, rl);
				else
					dropped = stage_row(r, MODE_SOME, off, len, rl);
			end
			OP_ALL: dropped = stage_row(r, MODE_ALL, 0, 0, rl);
			OP_NIL: dropped = stage_row(r, MODE_NONE, 0, 0, rl);
			OP_ROUND: begin
				round_ctr = round_ctr + 16'd1;
				if (round_ctr == 16'd0)
					foreach (tag_valid[k]) tag_valid[k] = 1'b0;
			end
			default: ;
		endcase
		if (row_fresh(r)) begin
			res.window_state = row_mode[r];
			res.covered = row_cov[r];
			res.segment_count = row_cnt[r];
		end else begin
			res.window_state = MODE_ALL;
			res.covered = '0;
			res.segment_count = '0;
		end
		res.overflow = dropped;
		return res;
	endfunction

	assign pending = expected_status_q.size();

	initial begin
		errors = 0;
		round_ctr = '0;
		foreach (tag_valid[k]) begin
			tag_valid[k] = 1'b0;
			tag_round[k] = '0;
			row_mode[k] = MODE_NONE;
			row_cov[k] = '0;
			row_cnt[k] = '0;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_status_q.push_back(apply_command(in_data));
			if (out_valid && out_ready) begin
				if (expected_status_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("result with nothing expected: %p", out_data);
				end else begin
					want = expected_status_q.pop_front();
					if (out_data.window_state !== want.window_state
							|| out_data.covered !== want.covered
							|| out_data.segment_count !== want.segment_count
							|| out_data.overflow !== want.overflow) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected state %0d cov %0d cnt %0d ovf %0d, got state %0d cov %0d cnt %0d ovf %0d",
								want.window_state, want.covered, want.segment_count, want.overflow,
								out_data.window_state, out_data.covered, out_data.segment_count,
								out_data.overflow);
					end
				end
			end
		end
	end

endmodule

/* sim/tb_row_window_interval_set.sv */
// Testbench top for the row window interval set: clock, reset, stimulus and verdict.
module tb_row_window_interval_set;
	import rwis_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	int        errors;
	int        pending;

	// Idle percentages for the two sides; the receiver hold counter forces a long stall.
	int          send_pct;
	int          recv_pct;
	int          hold_cycles;
	logic [14:0] row_len_of [64];

	row_window_interval_set u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	rwis_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog. Even with stalls on both sides, a correct run of about a thousand
	// items needs well under this.
	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

	// Receiver. It changes out_ready on the falling edge only. A pending hold request
	// keeps it low until the hold counter runs out while the sender keeps offering items.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles <= hold_cycles - 1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_pct);
			end
		end
	end

	// Offers one item and waits for its transfer. Valid is raised once the random
	// idle gap is over and stays high until in_ready is seen at a rising edge.
	task automatic send_cmd(logic [2:0] op, logic [5:0] r, logic [15:0] off,
			logic [15:0] len, logic [14:0] rl);
		in_item_t it;
		while ($urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		it.opcode = op;
		it.row = r;
		it.offset = off;
		it.length = len;
		it.row_length = rl;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// One random item. Most items follow the per-row length so that windows get
	// merged, inserted and completed; a few change the length or are pure noise.
	task automatic random_cmd();
		int pick, r, off, len, span;
		r = $urandom_range(0, 99) < 80 ? $urandom_range(0, 7) : $urandom_range(0, 63);
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			off = $urandom_range(0, row_len_of[r] - 1);
			span = row_len_of[r] - off;
			if ($urandom_range(0, 3) != 0)
				span = span < 8 ? span : 8;
			len = $urandom_range(1, span);
			send_cmd(OP_WINDOW, r[5:0], off[15:0], len[15:0], row_len_of[r]);
		end else if (pick < 66) begin
			send_cmd(OP_ALL, r[5:0], 16'($urandom), 16'($urandom), row_len_of[r]);
		end else if (pick < 71) begin
			send_cmd(OP_NIL, r[5:0], 16'($urandom), 16'($urandom), row_len_of[r]);
		end else if (pick < 80) begin
			send_cmd(OP_QUERY, r[5:0], 16'($urandom), 16'($urandom), row_len_of[r]);
		end else if (pick < 82) begin
			send_cmd(OP_ROUND, r[5:0], 16'($urandom), 16'($urandom), row_len_of[r]);
		end else if (pick < 88) begin
			// Change the row length; now and then use the largest one.
			row_len_of[r] = $urandom_range(0, 3) == 0 ? 15'h7fff : 15'($urandom_range(2, 400));
			send_cmd(OP_QUERY, r[5:0], 16'd0, 16'd1, row_len_of[r]);
		end else begin
			send_cmd(3'($urandom_range(0, 7)), 6'($urandom), 16'($urandom), 16'($urandom),
				15'($urandom));
		end
	endtask

	initial begin
		int ph, n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		send_pct = 0;
		recv_pct = 0;
		hold_cycles = 0;
		foreach (row_len_of[k]) row_len_of[k] = 15'($urandom_range(2, 300));
		row_len_of[0] = 15'd100;
		row_len_of[1] = 15'h7fff;
		row_len_of[2] = 15'd1000;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. A never written row reads as all.
		send_cmd(OP_QUERY, 6'd63, 16'h8000, 16'h7fff, 15'h7fff);
		// Invalid windows: negative offset, zero and negative length, past the end.
		send_cmd(OP_WINDOW, 6'd0, 16'hffff, 16'd5, 15'd100);
		send_cmd(OP_WINDOW, 6'd0, 16'd0, 16'd0, 15'd100);
		send_cmd(OP_WINDOW, 6'd0, 16'd3, 16'h8000, 15'd100);
		send_cmd(OP_WINDOW, 6'd0, 16'd90, 16'd11, 15'd100);
		// The full row stages all; stage nil then keeps the count.
		send_cmd(OP_WINDOW, 6'd0, 16'd0, 16'd100, 15'd100);
		send_cmd(OP_NIL, 6'd0, 16'd0, 16'd0, 15'd100);
		// Insert, equal segment, insert on the left, overlap merge, touch merge.
		send_cmd(OP_WINDOW, 6'd0, 16'd40, 16'd10, 15'd100);
		send_cmd(OP_WINDOW, 6'd0, 16'd40, 16'd10, 15'd100);
		send_cmd(OP_WINDOW, 6'd0, 16'd10, 16'd5, 15'd100);
		send_cmd(OP_WINDOW, 6'd0, 16'd45, 16'd20, 15'd100);
		send_cmd(OP_WINDOW, 6'd0, 16'd65, 16'd5, 15'd100);
		// Append on the right, then a window that overlaps two segments but widens only the first.
		send_cmd(OP_WINDOW, 6'd0, 16'd80, 16'd5, 15'd100);
		send_cmd(OP_WINDOW, 6'd0, 16'd0, 16'd50, 15'd100);
		send_cmd(OP_ALL, 6'd0, 16'd0, 16'd0, 15'd77);
		// Overlapping merges inflate the covered length until it saturates.
		send_cmd(OP_WINDOW, 6'd1, 16'd0, 16'd16000, 15'h7fff);
		send_cmd(OP_WINDOW, 6'd1, 16'd16500, 16'd15500, 15'h7fff);
		send_cmd(OP_WINDOW, 6'd1, 16'd100, 16'd16500, 15'h7fff);
		send_cmd(OP_WINDOW, 6'd1, 16'd200, 16'd32500, 15'h7fff);
		// Unused opcodes act as a query; a new round makes the row stale.
		send_cmd(OP_ROUND + 3'd1, 6'd1, 16'd0, 16'd0, 15'd0);
		send_cmd(OP_ROUND + 3'd3, 6'd0, 16'd0, 16'd0, 15'd0);
		send_cmd(OP_ROUND, 6'd1, 16'd0, 16'd0, 15'd0);
		send_cmd(OP_QUERY, 6'd0, 16'd0, 16'd0, 15'd0);
		// A fresh stage after the round renews the row.
		send_cmd(OP_WINDOW, 6'd0, 16'd5, 16'd5, 15'd100);
		// Fill one row with disjoint windows until the table overflows.
		for (n = 0; n < 18; n++)
			send_cmd(OP_WINDOW, 6'd2, 16'(n * 50), 16'd3, 15'd1000);

		// Random part in three idle settings.
		for (ph = 0; ph < 3; ph++) begin
			send_pct = ph == 0 ? 32 : (ph == 1 ? 48 : 0);
			recv_pct = ph == 0 ? 48 : (ph == 1 ? 32 : 0);
			for (n = 0; n < 303; n++) begin
				if (ph == 1 && n == 100)
					hold_cycles = 400;
				random_cmd();
			end
			// The sender rests until everything in flight has come back.
			wait_drained();
		end

		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* files.f */
rtl/rwis_pkg.sv
rtl/row_window_interval_set.sv
sim/rwis_checker.sv
sim/tb_row_window_interval_set.sv
